>>> sv/spos_pkg.sv
// ----------------------------------------------------------------------------
// spos_pkg
// Shared types and constants for the servo position PID loop: operation and
// status codes, register map, configuration record and datapath result.
// ----------------------------------------------------------------------------
package spos_pkg;

  // Operation codes carried on the input tuser
  typedef logic [1:0] op_t;
  localparam op_t OP_START  = 2'd0;
  localparam op_t OP_SAMPLE = 2'd1;
  localparam op_t OP_STOP   = 2'd2;

  // Status codes carried on the output tuser
  typedef logic [2:0] status_t;
  localparam status_t ST_IDLE    = 3'd0;
  localparam status_t ST_RUNNING = 3'd1;
  localparam status_t ST_ARRIVED = 3'd2;
  localparam status_t ST_LIMIT   = 3'd3;
  localparam status_t ST_TIMEOUT = 3'd4;
  localparam status_t ST_STOPPED = 3'd5;

  // Register indexes (byte address = 4 * index)
  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_PROP_GAIN     = 3'd0;
  localparam reg_idx_t REG_INTEGRAL_GAIN = 3'd1;
  localparam reg_idx_t REG_DERIV_GAIN    = 3'd2;
  localparam reg_idx_t REG_DRIVE_LIMIT   = 3'd3;
  localparam reg_idx_t REG_SETTLE_BAND   = 3'd4;
  localparam reg_idx_t REG_SETTLE_SPEED  = 3'd5;
  localparam reg_idx_t REG_MAX_SAMPLES   = 3'd6;

  // Register reset values
  localparam logic [15:0] RST_PROP_GAIN     = 16'd7680;  // 30.0 in Q8.8
  localparam logic [15:0] RST_INTEGRAL_GAIN = 16'd0;
  localparam logic [15:0] RST_DERIV_GAIN    = 16'd0;
  localparam logic [15:0] RST_DRIVE_LIMIT   = 16'd10000;
  localparam logic [7:0]  RST_SETTLE_BAND   = 8'd1;
  localparam logic [15:0] RST_SETTLE_SPEED  = 16'd100;
  localparam logic [23:0] RST_MAX_SAMPLES   = 24'd1000;

  typedef struct packed {
    logic [15:0] prop_gain;
    logic [15:0] integral_gain;
    logic [15:0] deriv_gain;
    logic [15:0] drive_limit;
    logic [7:0]  settle_band;
    logic [15:0] settle_speed;
    logic [23:0] max_samples;
  } cfg_t;

  // One pass of the control law
  typedef struct packed {
    logic signed [32:0] error;       // target minus distance moved
    logic signed [47:0] integ_nxt;   // saturated integrator after this sample
    logic signed [16:0] drive;       // clamped drive command
    logic               arrived;     // inside the band and still
  } pid_res_t;

endpackage

>>> sv/servo_position_pid_loop.sv
// ----------------------------------------------------------------------------
// servo_position_pid_loop
// Relative-move PID position servo for one axis with stream in/out and an
// APB register port.
// ----------------------------------------------------------------------------
// Each input item is a start, a control sample or a stop, and each produces
// exactly one result item. The block takes one item per clock while the
// output side is not stalled: an item sits in the input register while the
// control law (three parallel products of a 17-bit gain with the 33-bit
// error or the 34-bit error step, the integrator add with saturation, the
// sum, the Q8.8 scaling and the clamp) is evaluated, and the result lands in
// the output register, from which it leaves when the output side is not
// stalled. The integrator, previous error and sample count are updated in
// the same cycle as the result, so the next sample sees them without any
// hazard. A stalled output holds its result while one more item may wait
// in the input register. On a sample the checks run in order: timeout
// (sample count reached max_samples), the limit switch on the direction of
// travel, then arrival (|error| <= settle_band and |speed| < settle_speed);
// drive is nonzero only while running.
// Registers at byte address 4*i: prop_gain, integral_gain, deriv_gain,
// drive_limit, settle_band, settle_speed, max_samples. Write them only while
// the block is idle.
// ----------------------------------------------------------------------------
module servo_position_pid_loop (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // target_delta[31:0], position[63:32],
                                  // speed[87:64], left_limit[88],
                                  // right_limit[89], zero[95:90]
  input  logic [1:0]  in_tuser,   // op[1:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // drive[16:0], direction[17], zero[23:18]
  output logic [2:0]  out_tuser,  // status[2:0]
  // register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import spos_pkg::*;

  cfg_t     cfg;
  pid_res_t res;

  // Input register
  logic               in_valid_r;
  op_t                op_r;
  logic signed [31:0] tgt_r;
  logic signed [31:0] pos_r;
  logic signed [23:0] spd_r;
  logic               left_r;
  logic               right_r;

  // Move state
  logic               moving_r,     moving_nxt;
  logic signed [31:0] start_pos_r,  start_pos_nxt;
  logic signed [31:0] target_r,     target_nxt;
  logic signed [32:0] prev_err_r,   prev_err_nxt;
  logic signed [47:0] integ_r,      integ_nxt;
  logic        [23:0] count_r,      count_nxt;

  // Result register
  logic               out_valid_r;
  logic signed [16:0] drive_r,      drive_nxt;
  logic               dir_r;
  status_t            status_r,     status_nxt;

  logic advance;
  logic process;
  logic limit_hit;

  // Result moves on when the output register is empty or being drained
  assign advance   = !out_valid_r || out_tready;
  assign process   = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, dir_r, drive_r};
  assign out_tuser  = status_r;

  spos_cfg_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  spos_pid_core u_core (
    .cfg            (cfg),
    .position       (pos_r),
    .speed          (spd_r),
    .start_position (start_pos_r),
    .move_target    (target_r),
    .previous_error (prev_err_r),
    .integral_sum   (integ_r),
    .res            (res)
  );

  // Limit switch only counts on the side we are traveling toward
  assign limit_hit = (left_r && target_r[31]) ||
                     (right_r && !target_r[31] && (target_r != 32'sd0));

  always_comb begin
    moving_nxt    = moving_r;
    start_pos_nxt = start_pos_r;
    target_nxt    = target_r;
    prev_err_nxt  = prev_err_r;
    integ_nxt     = integ_r;
    count_nxt     = count_r;
    drive_nxt     = 17'sd0;
    status_nxt    = moving_r ? ST_RUNNING : ST_IDLE;

    if (op_r == OP_START) begin
      // Re-latch everything, also when a move is already running
      start_pos_nxt = pos_r;
      target_nxt    = tgt_r;
      prev_err_nxt  = 33'sd0;
      integ_nxt     = 48'sd0;
      count_nxt     = 24'd0;
      moving_nxt    = 1'b1;
      status_nxt    = ST_RUNNING;
    end else if (op_r == OP_STOP) begin
      moving_nxt = 1'b0;
      status_nxt = ST_STOPPED;
    end else if (op_r != OP_SAMPLE || !moving_r) begin
      // Hold: unknown op or sample while idle
    end else if (count_r >= cfg.max_samples) begin
      moving_nxt = 1'b0;
      status_nxt = ST_TIMEOUT;
    end else if (limit_hit) begin
      moving_nxt = 1'b0;
      status_nxt = ST_LIMIT;
    end else if (res.arrived) begin
      moving_nxt = 1'b0;
      status_nxt = ST_ARRIVED;
    end else begin
      integ_nxt    = res.integ_nxt;
      prev_err_nxt = res.error;
      count_nxt    = count_r + 24'd1;
      drive_nxt    = res.drive;
      status_nxt   = ST_RUNNING;
    end
  end

  // Input register: load on accept, drop once processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      op_r    <= in_tuser;
      tgt_r   <= in_tdata[31:0];
      pos_r   <= in_tdata[63:32];
      spd_r   <= in_tdata[87:64];
      left_r  <= in_tdata[88];
      right_r <= in_tdata[89];
    end
  end

  // Move state and result register: advance on each processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      moving_r    <= 1'b0;
      start_pos_r <= 32'sd0;
      target_r    <= 32'sd0;
      prev_err_r  <= 33'sd0;
      integ_r     <= 48'sd0;
      count_r     <= 24'd0;
    end else begin
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
      if (process) begin
        moving_r    <= moving_nxt;
        start_pos_r <= start_pos_nxt;
        target_r    <= target_nxt;
        prev_err_r  <= prev_err_nxt;
        integ_r     <= integ_nxt;
        count_r     <= count_nxt;
      end
    end
    if (process) begin
      drive_r  <= drive_nxt;
      dir_r    <= !target_nxt[31] && (target_nxt != 32'sd0);
      status_r <= status_nxt;
    end
  end

endmodule

>>> sv/spos_cfg_regs.sv
// ----------------------------------------------------------------------------
// spos_cfg_regs
// APB register file holding gains, drive clamp, settle thresholds and the
// timeout count.
// ----------------------------------------------------------------------------
module spos_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready,
  output spos_pkg::cfg_t     cfg
);
  import spos_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = cfg_paddr[4:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain     <= RST_PROP_GAIN;
      cfg_r.integral_gain <= RST_INTEGRAL_GAIN;
      cfg_r.deriv_gain    <= RST_DERIV_GAIN;
      cfg_r.drive_limit   <= RST_DRIVE_LIMIT;
      cfg_r.settle_band   <= RST_SETTLE_BAND;
      cfg_r.settle_speed  <= RST_SETTLE_SPEED;
      cfg_r.max_samples   <= RST_MAX_SAMPLES;
    end else if (wr_en) begin
      unique case (idx)
        REG_PROP_GAIN:     cfg_r.prop_gain     <= cfg_pwdata[15:0];
        REG_INTEGRAL_GAIN: cfg_r.integral_gain <= cfg_pwdata[15:0];
        REG_DERIV_GAIN:    cfg_r.deriv_gain    <= cfg_pwdata[15:0];
        REG_DRIVE_LIMIT:   cfg_r.drive_limit   <= cfg_pwdata[15:0];
        REG_SETTLE_BAND:   cfg_r.settle_band   <= cfg_pwdata[7:0];
        REG_SETTLE_SPEED:  cfg_r.settle_speed  <= cfg_pwdata[15:0];
        REG_MAX_SAMPLES:   cfg_r.max_samples   <= cfg_pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PROP_GAIN:     cfg_prdata = {16'd0, cfg_r.prop_gain};
      REG_INTEGRAL_GAIN: cfg_prdata = {16'd0, cfg_r.integral_gain};
      REG_DERIV_GAIN:    cfg_prdata = {16'd0, cfg_r.deriv_gain};
      REG_DRIVE_LIMIT:   cfg_prdata = {16'd0, cfg_r.drive_limit};
      REG_SETTLE_BAND:   cfg_prdata = {24'd0, cfg_r.settle_band};
      REG_SETTLE_SPEED:  cfg_prdata = {16'd0, cfg_r.settle_speed};
      REG_MAX_SAMPLES:   cfg_prdata = {8'd0, cfg_r.max_samples};
      default:           cfg_prdata = 32'd0;
    endcase
  end

endmodule

>>> sv/spos_pid_core.sv
// ----------------------------------------------------------------------------
// spos_pid_core
// Combinational control law: position error, settle test, saturating
// integrator, Q8.8 scaling and drive clamp.
// ----------------------------------------------------------------------------
module spos_pid_core (
  input  spos_pkg::cfg_t      cfg,
  input  logic signed [31:0]  position,
  input  logic signed [23:0]  speed,
  input  logic signed [31:0]  start_position,
  input  logic signed [31:0]  move_target,
  input  logic signed [32:0]  previous_error,
  input  logic signed [47:0]  integral_sum,
  output spos_pkg::pid_res_t  res
);
  import spos_pkg::*;

  localparam logic signed [50:0] INTEG_MAX = 51'sd140737488355327;
  localparam logic signed [50:0] INTEG_MIN = -51'sd140737488355328;

  logic signed [31:0] moved;
  logic signed [32:0] err;
  logic signed [33:0] derr;
  logic        [32:0] err_mag;
  logic        [23:0] spd_mag;
  logic signed [49:0] p_prod;
  logic signed [49:0] i_prod;
  logic signed [50:0] d_prod;
  logic signed [50:0] integ_sum;
  logic signed [47:0] integ_sat;
  logic signed [52:0] total;
  logic signed [44:0] quot;
  logic signed [44:0] quot_tz;
  logic signed [44:0] lim_pos;
  logic signed [44:0] lim_neg;
  logic signed [16:0] drive_c;

  always_comb begin
    // Distance moved wraps at 32 bits
    moved  = position - start_position;
    err    = 33'(move_target) - 33'(moved);
    derr   = 34'(err) - 34'(previous_error);

    err_mag = err[32] ? 33'(-err) : 33'(err);
    spd_mag = speed[23] ? 24'(-speed) : 24'(speed);

    p_prod = $signed({1'b0, cfg.prop_gain}) * err;
    i_prod = $signed({1'b0, cfg.integral_gain}) * err;
    d_prod = $signed({1'b0, cfg.deriv_gain}) * derr;

    // Integrator saturates to 48 bits
    integ_sum = 51'(integral_sum) + 51'(i_prod);
    if (integ_sum > INTEG_MAX) begin
      integ_sat = INTEG_MAX[47:0];
    end else if (integ_sum < INTEG_MIN) begin
      integ_sat = INTEG_MIN[47:0];
    end else begin
      integ_sat = integ_sum[47:0];
    end

    total = 53'(p_prod) + 53'(integ_sat) + 53'(d_prod);

    // Drop the Q8.8 fraction, rounding toward zero
    quot = total[52:8];
    if (total[52] && (total[7:0] != 8'd0)) begin
      quot_tz = quot + 45'sd1;
    end else begin
      quot_tz = quot;
    end

    lim_pos = $signed({29'd0, cfg.drive_limit});
    lim_neg = -lim_pos;
    if (quot_tz > lim_pos) begin
      drive_c = lim_pos[16:0];
    end else if (quot_tz < lim_neg) begin
      drive_c = lim_neg[16:0];
    end else begin
      drive_c = quot_tz[16:0];
    end

    res.error     = err;
    res.integ_nxt = integ_sat;
    res.drive     = drive_c;
    res.arrived   = (err_mag <= {25'd0, cfg.settle_band}) &&
                    (spd_mag < {8'd0, cfg.settle_speed});
  end

endmodule
